// ----- hw/rtl/h2ssm_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP/2 stream state machine package
// Shared types and codes for the front, queue and back sections.
// ----------------------------------------------------------------------------
`default_nettype none

package h2ssm_pkg;

    localparam int SLOT_W   = 6;
    localparam int IN_DW    = 24;
    localparam int IN_UW    = 2;
    localparam int OUT_DW   = 8;
    localparam int SLOT_XW  = 13;

    // op codes
    localparam logic [1:0] OP_RECV    = 2'd0;
    localparam logic [1:0] OP_SEND    = 2'd1;
    localparam logic [1:0] OP_OPEN    = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    // frame type bytes
    localparam logic [7:0] FTB_DATA     = 8'd0;
    localparam logic [7:0] FTB_HEADERS  = 8'd1;
    localparam logic [7:0] FTB_PRIORITY = 8'd2;
    localparam logic [7:0] FTB_RST      = 8'd3;
    localparam logic [7:0] FTB_WINDOW   = 8'd8;
    localparam logic [7:0] FTB_CONT     = 8'd9;

    // verdicts
    localparam logic [1:0] V_OK          = 2'd0;
    localparam logic [1:0] V_IGNORE      = 2'd1;
    localparam logic [1:0] V_TERM_STREAM = 2'd2;
    localparam logic [1:0] V_TERM_CONN   = 2'd3;

    // error codes
    localparam logic [1:0] E_NONE   = 2'd0;
    localparam logic [1:0] E_PROTO  = 2'd1;
    localparam logic [1:0] E_CLOSED = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_OPEN      = 3'd1,
        ST_HC_LOCAL  = 3'd2,
        ST_HC_REMOTE = 3'd3,
        ST_LOC_RESET = 3'd4,
        ST_CLOSED    = 3'd5
    } t_sstate;

    typedef enum logic [2:0] {
        FT_DATA,
        FT_HEADERS,
        FT_PRIORITY,
        FT_RST,
        FT_WINDOW,
        FT_CONT,
        FT_OTHER
    } t_ftype;

    typedef enum logic [1:0] {
        K_FRAME,
        K_SLOT_CLR,
        K_IGNORE
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              send;
        t_ftype            ftype;
        logic [SLOT_W-1:0] slot;
        logic              eh;
        logic              es;
        logic              pe;
        logic              rhes;
    } t_item;

    typedef struct packed {
        logic    tx_eos;
        logic    rx_eos;
        t_sstate st;
    } t_entry;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } t_owner;

endpackage

`default_nettype wire

// ----- hw/rtl/h2ssm_front.sv -----
// ----------------------------------------------------------------------------
// HTTP/2 stream state machine front end
// Accepts frame events, range-checks the slot and decodes the frame type.
// ----------------------------------------------------------------------------
`default_nettype none

module h2ssm_front
    import h2ssm_pkg::*;
#(
    parameter int NUM_STREAMS = 64
) (
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [IN_DW-1:0]  i_s_tdata,
    input  wire logic [IN_UW-1:0]  i_s_tuser,
    input  wire logic              i_q_full,
    input  wire logic              i_clearing,
    output logic                   o_push,
    output t_item                  o_item
);

    logic [1:0]        w_op;
    logic              w_svalid;
    logic [SLOT_W-1:0] w_slot;
    logic [7:0]        w_type;
    logic              w_range_bad;

    assign w_op     = i_s_tuser;
    assign w_svalid = i_s_tdata[0];
    assign w_slot   = i_s_tdata[6:1];
    assign w_type   = i_s_tdata[14:7];

    assign w_range_bad = ({{(32-SLOT_W){1'b0}}, w_slot} >= 32'(NUM_STREAMS));

    assign o_s_tready = !i_q_full && !i_clearing;
    assign o_push     = i_s_tvalid && o_s_tready;

    always_comb begin
        o_item.send = (w_op == OP_SEND);
        o_item.slot = w_slot;
        o_item.eh   = i_s_tdata[15];
        o_item.es   = i_s_tdata[16];
        o_item.pe   = i_s_tdata[17];
        o_item.rhes = i_s_tdata[18];

        if (w_range_bad) begin
            o_item.kind = K_IGNORE;
        end else if (w_op == OP_OPEN || w_op == OP_RELEASE) begin
            o_item.kind = K_SLOT_CLR;
        end else if (!w_svalid) begin
            o_item.kind = K_IGNORE;
        end else begin
            o_item.kind = K_FRAME;
        end

        case (w_type)
            FTB_DATA:     o_item.ftype = FT_DATA;
            FTB_HEADERS:  o_item.ftype = FT_HEADERS;
            FTB_PRIORITY: o_item.ftype = FT_PRIORITY;
            FTB_RST:      o_item.ftype = FT_RST;
            FTB_WINDOW:   o_item.ftype = FT_WINDOW;
            FTB_CONT:     o_item.ftype = FT_CONT;
            default:      o_item.ftype = FT_OTHER;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/h2ssm_queue.sv -----
// ----------------------------------------------------------------------------
// HTTP/2 stream state machine event queue
// Two-entry queue between the decode front end and the table back end.
// ----------------------------------------------------------------------------
`default_nettype none

module h2ssm_queue
    import h2ssm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    output logic       o_valid,
    output t_item      o_item,
    input  wire logic  i_pop
);

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/h2ssm_back.sv -----
// ----------------------------------------------------------------------------
// HTTP/2 stream state machine back end
// Stream table read-modify-write, header-block owners and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module h2ssm_back
    import h2ssm_pkg::*;
#(
    parameter int NUM_STREAMS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire t_item              i_q_item,
    output logic                    o_pop,
    output logic                    o_clearing,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [OUT_DW-1:0]       o_m_tdata
);

    localparam int AW = $clog2(NUM_STREAMS);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_bstate;

    t_bstate r_state, n_state;

    t_entry  r_mem [NUM_STREAMS];
    t_entry  r_rd_data;
    t_item   r_item;
    logic [AW-1:0] r_clr_cnt;

    t_owner  r_tx_own, n_tx_own;
    t_owner  r_rx_own, n_rx_own;

    logic              r_out_valid;
    logic [OUT_DW-1:0] r_out_data;

    logic [SLOT_XW-1:0] w_q_slot_x;
    logic [SLOT_XW-1:0] w_r_slot_x;
    logic [AW-1:0]      w_rd_addr;
    logic [AW-1:0]      w_wr_addr;
    logic               w_wr_en;
    t_entry             w_wr_data;
    logic               w_fire;

    // transition logic
    logic    w_send;
    t_owner  w_own;
    logic    w_own_v;
    logic [SLOT_W-1:0] w_own_s;
    t_entry  w_ent;
    logic    w_set_mark;
    logic    w_my_mark;
    logic    w_hdr_blk;
    logic    w_contig_bad;
    logic [1:0] w_verdict;
    logic [1:0] w_err;
    logic    w_drop;
    logic [1:0] w_out_v;
    logic [1:0] w_out_e;
    logic [2:0] w_out_s;

    assign w_q_slot_x = SLOT_XW'(i_q_item.slot);
    assign w_r_slot_x = SLOT_XW'(r_item.slot);
    assign w_rd_addr  = w_q_slot_x[AW-1:0];

    assign o_pop      = (r_state == S_IDLE) && i_q_valid;
    assign o_clearing = (r_state == S_CLEAR);
    assign w_fire     = (r_state == S_EXEC) && (!r_out_valid || i_m_tready);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign w_send    = r_item.send;
    assign w_own     = w_send ? r_tx_own : r_rx_own;
    assign w_my_mark = w_send ? r_rd_data.tx_eos : r_rd_data.rx_eos;

    assign w_contig_bad =
        (w_own.valid && w_own.slot != r_item.slot) ||
        (w_own.valid && r_item.ftype != FT_CONT && r_item.ftype != FT_RST) ||
        (!w_own.valid && r_item.ftype == FT_CONT);

    always_comb begin
        w_ent      = r_rd_data;
        w_own_v    = w_own.valid;
        w_own_s    = w_own.slot;
        w_verdict  = V_OK;
        w_err      = E_NONE;
        w_set_mark = 1'b0;
        w_hdr_blk  = 1'b0;

        if (w_contig_bad) begin
            w_verdict = V_TERM_CONN;
            w_err     = E_PROTO;
        end else begin
            case (r_rd_data.st)
                ST_IDLE: begin
                    if (w_send) begin
                        w_verdict = V_IGNORE;
                    end else if (r_item.ftype == FT_HEADERS) begin
                        if (r_item.eh && r_item.es) begin
                            w_ent.st = ST_HC_REMOTE;
                        end else begin
                            if (!r_item.eh) begin
                                w_own_v = 1'b1;
                                w_own_s = r_item.slot;
                            end
                            if (!r_item.eh && r_item.es) begin
                                w_ent.rx_eos = 1'b1;
                            end
                            w_ent.st = ST_OPEN;
                        end
                    end else if (r_item.ftype != FT_PRIORITY) begin
                        w_verdict = V_TERM_CONN;
                        w_err     = E_PROTO;
                    end
                end
                ST_OPEN: begin
                    case (r_item.ftype)
                        FT_RST: begin
                            w_ent.st = w_send ? ST_LOC_RESET : ST_CLOSED;
                        end
                        FT_CONT: begin
                            if (w_own.valid && !r_item.eh && r_item.pe) begin
                                w_verdict = V_TERM_CONN;
                                w_err     = E_PROTO;
                            end else if (r_item.eh) begin
                                w_own_v = 1'b0;
                                if (w_my_mark) begin
                                    w_ent.st = w_send ? ST_HC_LOCAL : ST_HC_REMOTE;
                                end
                            end else begin
                                w_own_v = 1'b1;
                                w_own_s = r_item.slot;
                            end
                        end
                        FT_HEADERS: begin
                            if (r_item.eh && r_item.es) begin
                                w_own_v = 1'b0;
                                if (!w_send) begin
                                    w_ent.rx_eos = 1'b1;
                                end
                                w_ent.st = w_send ? ST_HC_LOCAL : ST_HC_REMOTE;
                            end else begin
                                w_own_v    = 1'b1;
                                w_own_s    = r_item.slot;
                                w_set_mark = r_item.es;
                            end
                        end
                        FT_DATA: begin
                            if (r_item.pe && !r_item.rhes) begin
                                w_verdict = V_TERM_CONN;
                                w_err     = E_PROTO;
                            end else if (r_item.es) begin
                                w_ent.st = w_send ? ST_HC_LOCAL : ST_HC_REMOTE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                ST_HC_LOCAL: begin
                    if (!w_send) begin
                        if (r_item.ftype == FT_RST) begin
                            w_ent.st = ST_CLOSED;
                        end else if (r_item.ftype == FT_HEADERS ||
                                     r_item.ftype == FT_CONT) begin
                            w_hdr_blk = 1'b1;
                        end else if (r_item.ftype == FT_DATA && r_item.es) begin
                            w_ent.st = ST_CLOSED;
                        end
                    end else if (r_item.ftype == FT_RST) begin
                        w_ent.st = ST_LOC_RESET;
                    end else if (r_item.ftype != FT_PRIORITY &&
                                 r_item.ftype != FT_WINDOW) begin
                        w_verdict = V_IGNORE;
                    end
                end
                ST_HC_REMOTE: begin
                    if (w_send) begin
                        if (r_item.ftype == FT_HEADERS || r_item.ftype == FT_CONT) begin
                            w_hdr_blk = 1'b1;
                        end else if ((r_item.ftype == FT_DATA && r_item.es) ||
                                     r_item.ftype == FT_RST) begin
                            w_ent.st = ST_CLOSED;
                        end
                    end else if (r_item.ftype == FT_RST) begin
                        w_ent.st = ST_CLOSED;
                    end else if (r_item.ftype != FT_PRIORITY &&
                                 r_item.ftype != FT_WINDOW) begin
                        w_ent.st  = ST_CLOSED;
                        w_verdict = V_TERM_STREAM;
                        w_err     = E_CLOSED;
                    end
                end
                ST_LOC_RESET: begin
                    if (w_send) begin
                        w_verdict = V_IGNORE;
                    end else if (r_item.ftype == FT_RST) begin
                        w_ent.st = ST_CLOSED;
                    end else if (r_item.ftype != FT_WINDOW) begin
                        w_verdict = V_IGNORE;
                    end
                end
                default: begin
                    if (w_send) begin
                        w_verdict = V_IGNORE;
                    end else if (r_item.ftype != FT_PRIORITY) begin
                        w_verdict = V_TERM_CONN;
                        w_err     = E_PROTO;
                    end
                end
            endcase

            // header block on a half-closed stream
            if (w_hdr_blk) begin
                if (r_item.eh && r_item.es) begin
                    w_own_v  = 1'b0;
                    w_ent.st = ST_CLOSED;
                end else if (r_item.eh) begin
                    w_own_v = 1'b0;
                end else begin
                    w_own_v    = 1'b1;
                    w_own_s    = r_item.slot;
                    w_set_mark = r_item.es;
                end
            end

            if (w_set_mark) begin
                if (w_send) begin
                    w_ent.tx_eos = 1'b1;
                end else begin
                    w_ent.rx_eos = 1'b1;
                end
            end
        end
    end

    assign w_drop = (r_item.ftype == FT_RST) || (w_verdict == V_TERM_STREAM);

    always_comb begin
        n_tx_own = r_tx_own;
        n_rx_own = r_rx_own;
        w_out_v  = V_IGNORE;
        w_out_e  = E_NONE;
        w_out_s  = 3'(ST_IDLE);
        case (r_item.kind)
            K_FRAME: begin
                if (w_send) begin
                    n_tx_own.valid = w_own_v;
                    n_tx_own.slot  = w_own_s;
                end else begin
                    n_rx_own.valid = w_own_v;
                    n_rx_own.slot  = w_own_s;
                end
                if (w_drop) begin
                    if (n_tx_own.slot == r_item.slot) begin
                        n_tx_own.valid = 1'b0;
                    end
                    if (n_rx_own.slot == r_item.slot) begin
                        n_rx_own.valid = 1'b0;
                    end
                end
                w_out_v = w_verdict;
                w_out_e = w_err;
                w_out_s = 3'(w_ent.st);
            end
            K_SLOT_CLR: begin
                if (r_tx_own.slot == r_item.slot) begin
                    n_tx_own.valid = 1'b0;
                end
                if (r_rx_own.slot == r_item.slot) begin
                    n_rx_own.valid = 1'b0;
                end
                w_out_v = V_OK;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = w_r_slot_x[AW-1:0];
        w_wr_data = w_ent;
        if (r_state == S_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_cnt;
            w_wr_data = '0;
        end else if (w_fire) begin
            case (r_item.kind)
                K_FRAME:    w_wr_en = 1'b1;
                K_SLOT_CLR: begin
                    w_wr_en   = 1'b1;
                    w_wr_data = '0;
                end
                default:    w_wr_en = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == AW'(NUM_STREAMS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_tx_own    <= '0;
            r_rx_own    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (w_fire) begin
                r_tx_own    <= n_tx_own;
                r_rx_own    <= n_rx_own;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_q_item;
        end
        if (w_fire) begin
            r_out_data <= {1'b0, w_out_s, w_out_e, w_out_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (o_pop) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/http2_stream_state_machine.sv -----
// Each accepted event waits in the queue, then its stream table entry is read,
// then it is executed, written back and placed in the result register. The back
// end takes no new event from the queue until the last one has been executed and
// written (stream table read-modify-write). Reset: owners clear at once; the stream
// table is then swept to idle, one entry a cycle, with o_s_tready held low.
// ----------------------------------------------------------------------------
// HTTP/2 stream state machine
// Per-stream RFC 9113 transitions with header-block contiguity checks.
// ----------------------------------------------------------------------------
`default_nettype none

module http2_stream_state_machine
    import h2ssm_pkg::*;
#(
    parameter int NUM_STREAMS = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // stream_valid, stream_slot[6], frame_type[8], hdr_done, eos_flag,
    // payload_empty, rx_hdr_eos, zero pad
    input  wire logic [IN_DW-1:0]  i_s_tdata,
    // op[2]
    input  wire logic [IN_UW-1:0]  i_s_tuser,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // verdict[2], error_code[2], stream_state[3], zero pad
    output logic [OUT_DW-1:0]      o_m_tdata
);

    logic  w_push;
    t_item w_f_item;
    logic  w_q_full;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_pop;
    logic  w_clearing;

    h2ssm_front #(
        .NUM_STREAMS (NUM_STREAMS)
    ) u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (w_q_full),
        .i_clearing (w_clearing),
        .o_push     (w_push),
        .o_item     (w_f_item)
    );

    h2ssm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_f_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    h2ssm_back #(
        .NUM_STREAMS (NUM_STREAMS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire

// ----- tb/http2_stream_state_machine_tb.sv -----
// ----------------------------------------------------------------------------
// HTTP/2 stream state machine testbench
// Drives frame, open and release events into the stream table and checks
// every verdict, error code and new stream state against a local model of
// the stream transitions and header-block contiguity rules. Both sides of
// the stream interface idle at random and the result side holds off once
// for a long stretch.
// ----------------------------------------------------------------------------
module http2_stream_state_machine_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import h2ssm_pkg::*;

    localparam int NSLOTS = 64;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [IN_DW-1:0]  i_s_tdata  = '0;
    logic [IN_UW-1:0]  i_s_tuser  = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [OUT_DW-1:0] o_m_tdata;

    typedef struct {
        logic [1:0]        op;
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        ftype;
        logic              eh;
        logic              es;
        logic              pe;
        logic              rhes;
    } t_frame_event;

    typedef struct packed {
        logic [1:0] verdict;
        logic [1:0] err;
        logic [2:0] state;
    } t_outcome;

    t_sstate           model_st [NSLOTS];
    logic              model_rx_eos [NSLOTS];
    logic              model_tx_eos [NSLOTS];
    t_owner            model_send_owner;
    t_owner            model_recv_owner;
    t_outcome          pending_outcomes [$];
    logic [SLOT_W-1:0] hot_slots [4];

    int n_sent;
    int n_checked;
    int n_errors;
    int verdict_seen [4];
    bit tx_calm;
    bit rx_calm;
    bit rx_hold_req;

    always #4 i_clk = ~i_clk;

    http2_stream_state_machine #(
        .NUM_STREAMS(NSLOTS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // ------------------------------------------------------------------------
    // Stream table model
    // ------------------------------------------------------------------------
    function automatic void release_owners(input logic [SLOT_W-1:0] slot);
        if (model_send_owner.valid && model_send_owner.slot == slot) begin
            model_send_owner = '0;
        end
        if (model_recv_owner.valid && model_recv_owner.slot == slot) begin
            model_recv_owner = '0;
        end
    endfunction

    // header or continuation frame on a half-closed stream
    function automatic void close_header_block(inout t_sstate st, inout t_owner own,
                                               inout logic mark,
                                               input logic [SLOT_W-1:0] slot,
                                               input logic eh, input logic es);
        if (eh && es) begin
            own.valid = 1'b0;
            st = ST_CLOSED;
        end else if (eh) begin
            own.valid = 1'b0;
        end else begin
            own.valid = 1'b1;
            own.slot  = slot;
            if (es) mark = 1'b1;
        end
    endfunction

    function automatic t_outcome predict_outcome(input t_frame_event ev);
        t_outcome res;
        t_owner   own;
        t_sstate  st;
        logic     rx;
        logic     tx;
        logic     snd;
        int       s;
        res.verdict = V_OK;
        res.err     = E_NONE;
        res.state   = ST_IDLE;
        s = ev.slot;
        if (ev.op == OP_OPEN || ev.op == OP_RELEASE) begin
            model_st[s]     = ST_IDLE;
            model_rx_eos[s] = 1'b0;
            model_tx_eos[s] = 1'b0;
            release_owners(ev.slot);
            return res;
        end
        if (!ev.valid) begin
            res.verdict = V_IGNORE;
            return res;
        end
        snd = (ev.op == OP_SEND);
        own = snd ? model_send_owner : model_recv_owner;
        st  = model_st[s];
        rx  = model_rx_eos[s];
        tx  = model_tx_eos[s];

        if ((own.valid && own.slot != ev.slot) ||
            (own.valid && ev.ftype != FTB_CONT && ev.ftype != FTB_RST) ||
            (!own.valid && ev.ftype == FTB_CONT)) begin
            res.verdict = V_TERM_CONN;
            res.err     = E_PROTO;
        end else begin
            case (st)
                ST_IDLE: begin
                    if (snd) begin
                        res.verdict = V_IGNORE;
                    end else if (ev.ftype == FTB_HEADERS) begin
                        if (ev.eh && ev.es) begin
                            st = ST_HC_REMOTE;
                        end else begin
                            if (!ev.eh) begin
                                own.valid = 1'b1;
                                own.slot  = ev.slot;
                            end
                            if (!ev.eh && ev.es) rx = 1'b1;
                            st = ST_OPEN;
                        end
                    end else if (ev.ftype != FTB_PRIORITY) begin
                        res.verdict = V_TERM_CONN;
                        res.err     = E_PROTO;
                    end
                end
                ST_OPEN: begin
                    if (ev.ftype == FTB_RST) begin
                        st = snd ? ST_LOC_RESET : ST_CLOSED;
                    end else if (ev.ftype == FTB_CONT) begin
                        if (own.valid && !ev.eh && ev.pe) begin
                            res.verdict = V_TERM_CONN;
                            res.err     = E_PROTO;
                        end else if (ev.eh) begin
                            own.valid = 1'b0;
                            if (snd ? tx : rx) st = snd ? ST_HC_LOCAL : ST_HC_REMOTE;
                        end else begin
                            own.valid = 1'b1;
                            own.slot  = ev.slot;
                        end
                    end else if (ev.ftype == FTB_HEADERS) begin
                        if (ev.eh && ev.es) begin
                            own.valid = 1'b0;
                            if (!snd) rx = 1'b1;
                            st = snd ? ST_HC_LOCAL : ST_HC_REMOTE;
                        end else begin
                            own.valid = 1'b1;
                            own.slot  = ev.slot;
                            if (ev.es) begin
                                if (snd) tx = 1'b1;
                                else rx = 1'b1;
                            end
                        end
                    end else if (ev.ftype == FTB_DATA) begin
                        if (ev.pe && !ev.rhes) begin
                            res.verdict = V_TERM_CONN;
                            res.err     = E_PROTO;
                        end else if (ev.es) begin
                            st = snd ? ST_HC_LOCAL : ST_HC_REMOTE;
                        end
                    end
                end
                ST_HC_LOCAL: begin
                    if (!snd) begin
                        if (ev.ftype == FTB_RST) begin
                            st = ST_CLOSED;
                        end else if (ev.ftype == FTB_HEADERS || ev.ftype == FTB_CONT) begin
                            close_header_block(st, own, rx, ev.slot, ev.eh, ev.es);
                        end else if (ev.ftype == FTB_DATA && ev.es) begin
                            st = ST_CLOSED;
                        end
                    end else if (ev.ftype == FTB_RST) begin
                        st = ST_LOC_RESET;
                    end else if (ev.ftype != FTB_PRIORITY && ev.ftype != FTB_WINDOW) begin
                        res.verdict = V_IGNORE;
                    end
                end
                ST_HC_REMOTE: begin
                    if (snd) begin
                        if (ev.ftype == FTB_HEADERS || ev.ftype == FTB_CONT) begin
                            close_header_block(st, own, tx, ev.slot, ev.eh, ev.es);
                        end else if ((ev.ftype == FTB_DATA && ev.es) ||
                                     ev.ftype == FTB_RST) begin
                            st = ST_CLOSED;
                        end
                    end else if (ev.ftype == FTB_RST) begin
                        st = ST_CLOSED;
                    end else if (ev.ftype != FTB_PRIORITY && ev.ftype != FTB_WINDOW) begin
                        st          = ST_CLOSED;
                        res.verdict = V_TERM_STREAM;
                        res.err     = E_CLOSED;
                    end
                end
                ST_LOC_RESET: begin
                    if (snd) begin
                        res.verdict = V_IGNORE;
                    end else if (ev.ftype == FTB_RST) begin
                        st = ST_CLOSED;
                    end else if (ev.ftype != FTB_WINDOW) begin
                        res.verdict = V_IGNORE;
                    end
                end
                default: begin
                    if (snd) begin
                        res.verdict = V_IGNORE;
                    end else if (ev.ftype != FTB_PRIORITY) begin
                        res.verdict = V_TERM_CONN;
                        res.err     = E_PROTO;
                    end
                end
            endcase
        end

        if (snd) model_send_owner = own;
        else model_recv_owner = own;
        model_st[s]     = st;
        model_rx_eos[s] = rx;
        model_tx_eos[s] = tx;
        if (ev.ftype == FTB_RST || res.verdict == V_TERM_STREAM) release_owners(ev.slot);
        res.state = st;
        return res;
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < NSLOTS; i++) begin
            model_st[i]     = ST_IDLE;
            model_rx_eos[i] = 1'b0;
            model_tx_eos[i] = 1'b0;
        end
        model_send_owner = '0;
        model_recv_owner = '0;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_frame_event make_event(input logic [1:0] op, input logic valid,
                                                input logic [SLOT_W-1:0] slot,
                                                input logic [7:0] ftype,
                                                input logic eh, input logic es,
                                                input logic pe, input logic rhes);
        t_frame_event ev;
        ev.op    = op;
        ev.valid = valid;
        ev.slot  = slot;
        ev.ftype = ftype;
        ev.eh    = eh;
        ev.es    = es;
        ev.pe    = pe;
        ev.rhes  = rhes;
        return ev;
    endfunction

    // mostly live traffic on a few hot streams; open header blocks are
    // usually continued so that the later states are reached
    function automatic t_frame_event random_event();
        t_frame_event ev;
        t_owner       own;
        int           r;
        r = $urandom_range(0, 99);
        ev.op = (r < 46) ? OP_RECV : (r < 88) ? OP_SEND : (r < 94) ? OP_OPEN : OP_RELEASE;
        ev.valid = ($urandom_range(0, 19) != 0);
        ev.slot  = ($urandom_range(0, 9) < 8) ? hot_slots[$urandom_range(0, 3)]
                                              : SLOT_W'($urandom_range(0, NSLOTS - 1));
        ev.eh    = ($urandom_range(0, 9) < 6);
        ev.es    = 1'($urandom_range(0, 1));
        ev.pe    = ($urandom_range(0, 4) == 0);
        ev.rhes  = ($urandom_range(0, 3) != 0);
        r = $urandom_range(0, 99);
        if (r < 20)      ev.ftype = FTB_DATA;
        else if (r < 38) ev.ftype = FTB_HEADERS;
        else if (r < 46) ev.ftype = FTB_PRIORITY;
        else if (r < 56) ev.ftype = FTB_RST;
        else if (r < 64) ev.ftype = FTB_WINDOW;
        else if (r < 80) ev.ftype = FTB_CONT;
        else             ev.ftype = 8'($urandom_range(0, 255));
        own = (ev.op == OP_SEND) ? model_send_owner : model_recv_owner;
        if (own.valid && (ev.op == OP_RECV || ev.op == OP_SEND) &&
            $urandom_range(0, 9) < 8) begin
            ev.valid = 1'b1;
            ev.slot  = own.slot;
            ev.ftype = FTB_CONT;
        end
        return ev;
    endfunction

    task automatic send_event(input t_frame_event ev);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= ev.op;
        // valid, slot, type, hdr_done, eos_flag, payload_empty, rx_hdr_eos, pad
        i_s_tdata  <= {5'b0, ev.rhes, ev.pe, ev.es, ev.eh, ev.ftype, ev.slot, ev.valid};
        do @(posedge i_clk); while (!o_s_tready);
        pending_outcomes.push_back(predict_outcome(ev));
        n_sent++;
        gap = idle_len(tx_calm);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic report_mismatch(input string what, input t_outcome want,
                                   input t_outcome got);
        n_errors++;
        if (n_errors <= 10) begin
            $display("[%0t] %s: exp verdict %0d err %0d state %0d, got verdict %0d err %0d state %0d",
                     $realtime, what, want.verdict, want.err, want.state,
                     got.verdict, got.err, got.state);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls and checking of each transfer
    // ------------------------------------------------------------------------
    initial begin : verdict_checker
        int       hold;
        int       g;
        t_outcome got;
        t_outcome want;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got.verdict = o_m_tdata[1:0];
                got.err     = o_m_tdata[3:2];
                got.state   = o_m_tdata[6:4];
                n_checked++;
                verdict_seen[got.verdict]++;
                if (pending_outcomes.size() == 0) begin
                    report_mismatch("unexpected transfer", '0, got);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (got.verdict != want.verdict || got.err != want.err ||
                        got.state != want.state) begin
                        report_mismatch("mismatch", want, got);
                    end
                end
            end
            if (rx_hold_req) begin
                hold = 300;
                rx_hold_req = 1'b0;
            end
            if (hold > 0) begin
                i_m_tready <= 1'b0;
                hold--;
            end else begin
                g = idle_len(rx_calm);
                if (g == 0) begin
                    i_m_tready <= 1'b1;
                end else begin
                    i_m_tready <= 1'b0;
                    hold = g - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_cases();
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        // no stream
        send_event(make_event(OP_RECV, 1'b0, 6'd63, 8'hff, 1'b1, 1'b1, 1'b1, 1'b1));
        send_event(make_event(OP_OPEN, 1'b0, 6'd0, 8'hff, 1'b1, 1'b1, 1'b1, 1'b1));
        // header block left open on slot 0
        send_event(make_event(OP_RECV, 1'b1, 6'd0, FTB_HEADERS, 1'b0, 1'b1, 1'b0, 1'b1));
        send_event(make_event(OP_RECV, 1'b1, 6'd5, FTB_DATA, 1'b0, 1'b0, 1'b0, 1'b1));
        send_event(make_event(OP_RECV, 1'b1, 6'd0, FTB_DATA, 1'b0, 1'b0, 1'b0, 1'b1));
        // empty continuation
        send_event(make_event(OP_RECV, 1'b1, 6'd0, FTB_CONT, 1'b0, 1'b0, 1'b1, 1'b1));
        send_event(make_event(OP_RECV, 1'b1, 6'd0, FTB_CONT, 1'b1, 1'b0, 1'b0, 1'b1));
        // continuation with no open block
        send_event(make_event(OP_RECV, 1'b1, 6'd0, FTB_CONT, 1'b1, 1'b0, 1'b0, 1'b1));
        send_event(make_event(OP_RECV, 1'b1, 6'd0, FTB_DATA, 1'b0, 1'b0, 1'b0, 1'b1));
        send_event(make_event(OP_RECV, 1'b1, 6'd0, FTB_PRIORITY, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(OP_SEND, 1'b1, 6'd0, FTB_DATA, 1'b0, 1'b1, 1'b0, 1'b0));
        send_event(make_event(OP_RELEASE, 1'b0, 6'd0, 8'hff, 1'b1, 1'b1, 1'b1, 1'b1));
        // send on idle stream
        send_event(make_event(OP_SEND, 1'b1, 6'd63, FTB_HEADERS, 1'b1, 1'b0, 1'b0, 1'b0));
        send_event(make_event(OP_RECV, 1'b1, 6'd63, FTB_HEADERS, 1'b1, 1'b0, 1'b0, 1'b0));
        // empty DATA, both directions
        send_event(make_event(OP_RECV, 1'b1, 6'd63, FTB_DATA, 1'b0, 1'b0, 1'b1, 1'b0));
        send_event(make_event(OP_SEND, 1'b1, 6'd63, FTB_DATA, 1'b0, 1'b0, 1'b1, 1'b0));
        // unknown type on an open stream
        send_event(make_event(OP_RECV, 1'b1, 6'd63, 8'hff, 1'b1, 1'b1, 1'b1, 1'b1));
        send_event(make_event(OP_SEND, 1'b1, 6'd63, FTB_RST, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(OP_RECV, 1'b1, 6'd63, FTB_WINDOW, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(OP_RECV, 1'b1, 6'd63, FTB_DATA, 1'b0, 1'b1, 1'b0, 1'b1));
        send_event(make_event(OP_RECV, 1'b1, 6'd63, FTB_RST, 1'b0, 1'b0, 1'b0, 1'b0));
        send_event(make_event(OP_RECV, 1'b1, 6'd63, FTB_HEADERS, 1'b1, 1'b1, 1'b0, 1'b0));
        send_event(make_event(OP_RECV, 1'b1, 6'd10, FTB_DATA, 1'b0, 1'b0, 1'b0, 1'b1));
        send_event(make_event(OP_RECV, 1'b1, 6'd10, 8'd4, 1'b0, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_backpressure();
        tx_calm = 1'b1;
        hot_slots = '{6'd3, 6'd4, 6'd40, 6'd41};
        rx_hold_req = 1'b1;
        repeat (40) send_event(random_event());
    endtask

    task automatic test_random_traffic(input int n_items);
        for (int phase = 0; phase < 4; phase++) begin
            tx_calm = (phase == 0) || (phase == 2);
            rx_calm = (phase == 0) || (phase == 1);
            if (phase == 0) begin
                hot_slots = '{6'd0, 6'd63, 6'd1, 6'd62};
            end else begin
                for (int i = 0; i < 4; i++) hot_slots[i] = SLOT_W'($urandom_range(0, NSLOTS - 1));
            end
            repeat (n_items / 4) send_event(random_event());
        end
    endtask

    initial begin : watchdog
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : main
        int drain;
        n_sent      = 0;
        n_checked   = 0;
        n_errors    = 0;
        rx_hold_req = 1'b0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        verdict_seen = '{0, 0, 0, 0};
        reset_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_backpressure();
        test_random_traffic(1640);
        i_s_tvalid <= 1'b0;

        drain = 0;
        while (pending_outcomes.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (16) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            n_errors += pending_outcomes.size();
            $display("%0d results never arrived", pending_outcomes.size());
        end

        $display("%0d events sent, %0d results checked, %0d errors", n_sent, n_checked,
                 n_errors);
        $display("verdicts: ok %0d, ignore %0d, stream reset %0d, connection error %0d",
                 verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3]);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/h2ssm_pkg.sv
hw/rtl/h2ssm_front.sv
hw/rtl/h2ssm_queue.sv
hw/rtl/h2ssm_back.sv
hw/rtl/http2_stream_state_machine.sv
tb/http2_stream_state_machine_tb.sv
